FILE: hdl/rdat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rdat_pkg;

   typedef enum logic [1:0] {
      FUNC_RECEIVE = 2'd0,
      FUNC_SEND    = 2'd1,
      FUNC_TICK    = 2'd2,
      FUNC_OTHER   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ACT_TX_NEW  = 3'd0,
      ACT_TX_ACK  = 3'd1,
      ACT_RETX    = 3'd2,
      ACT_DELIVER = 3'd3,
      ACT_STATUS  = 3'd4
   } action_type;

   // Classified operations handed from the front end to the back end.
   typedef enum logic [2:0] {
      OP_RX_ACK  = 3'd0,
      OP_RX_DATA = 3'd1,
      OP_TX_ACK  = 3'd2,
      OP_TX_DATA = 3'd3,
      OP_TICK    = 3'd4,
      OP_STATUS  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEEN_SCAN,
      ST_SEEN_WAIT,
      ST_SLOT_SCAN,
      ST_EMIT,
      ST_DELIVER,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] seq;
      logic [12:0] len;
      logic [31:0] now;
      logic        tmo;
   } cmd_type;

   localparam logic [15:0] REDELIVER_RESET  = 16'd1000;
   localparam logic [15:0] CONNECTION_RESET = 16'd15000;
   localparam logic        CSR_REDELIVER    = 1'b0;
   localparam logic        CSR_CONNECTION   = 1'b1;

endpackage
`default_nettype wire

FILE: hdl/rdat_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rdat_front #(
   parameter int MAX_PAYLOAD = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_func,
   input  wire logic                  req_is_ack,
   input  wire logic [31:0]           req_seq_in,
   input  wire logic [12:0]           req_payload_length,
   input  wire logic [31:0]           req_now_ms,
   input  wire logic [15:0]           conn_timeout,
   output logic                       cmd_valid,
   input  wire logic                  cmd_ready,
   output rdat_pkg::cmd_type          cmd
);
   import rdat_pkg::*;

   localparam logic [12:0] MaxLen = 13'(MAX_PAYLOAD);

   // Two-entry queue toward the back end.
   cmd_type     q_ff [2];
   cmd_type     q_in [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] last_rx_ff, last_rx_in;
   cmd_type     c;
   logic [31:0] lr;
   logic        take, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign take      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[0];
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      lr = (func_type'(req_func) == FUNC_RECEIVE) ? req_now_ms : last_rx_ff;
      c.seq = req_seq_in;
      c.len = (req_payload_length > MaxLen) ? MaxLen : req_payload_length;
      c.now = req_now_ms;
      c.tmo = ((req_now_ms - lr) > {16'd0, conn_timeout});
      unique case (func_type'(req_func))
         FUNC_RECEIVE: c.op = req_is_ack ? OP_RX_ACK : OP_RX_DATA;
         FUNC_SEND:    c.op = req_is_ack ? OP_TX_ACK : OP_TX_DATA;
         FUNC_TICK:    c.op = OP_TICK;
         default:      c.op = OP_STATUS;
      endcase
      last_rx_in = take ? lr : last_rx_ff;
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_ff - 2'd1;
      end
      if (take) begin
         q_in[cnt_in[0]] = c;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff     <= 2'd0;
         last_rx_ff <= 32'd0;
      end else begin
         cnt_ff     <= cnt_in;
         last_rx_ff <= last_rx_in;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/rdat_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rdat_back #(
   parameter int SEEN_WINDOW   = 1024,
   parameter int PENDING_SLOTS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   output logic                      cmd_ready,
   input  rdat_pkg::cmd_type         cmd,
   input  wire logic [15:0]          redeliver_timeout,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0]                rsp_action,
   output logic [31:0]               rsp_seq_out,
   output logic [12:0]               rsp_length_out,
   output logic [4:0]                rsp_slot_out,
   output logic                      rsp_table_full,
   output logic                      rsp_timed_out,
   output logic                      rsp_last
);
   import rdat_pkg::*;

   localparam int SW = (SEEN_WINDOW > 1) ? $clog2(SEEN_WINDOW) : 1;
   localparam int CW = $clog2(SEEN_WINDOW + 1);
   localparam int PW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
   localparam int IW = $clog2(PENDING_SLOTS + 1);
   localparam logic [CW-1:0] SeenFull = CW'(SEEN_WINDOW);
   localparam logic [SW-1:0] SeenLast = SW'(SEEN_WINDOW - 1);
   localparam logic [IW-1:0] SlotEnd  = IW'(PENDING_SLOTS);

   logic [31:0] seen_mem [SEEN_WINDOW];
   logic [31:0] seen_rd_ff;
   logic [31:0] p_seq   [PENDING_SLOTS];
   logic [31:0] p_stamp [PENDING_SLOTS];
   logic [12:0] p_len   [PENDING_SLOTS];
   logic [PENDING_SLOTS-1:0] p_valid_ff, p_valid_in;

   state_type   state_ff, state_in;
   cmd_type     cur_ff, cur_in;
   logic [31:0] next_seq_ff, next_seq_in;
   logic [CW-1:0] seen_cnt_ff, seen_cnt_in, idx_ff, idx_in;
   logic [SW-1:0] seen_old_ff, seen_old_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic        any_ff, any_in;
   logic        dup_ff, dup_in;
   logic        rd_pend_in;
   logic        seen_we;
   logic [SW-1:0] seen_waddr, seen_raddr;

   // Retransmission held back until the scan shows whether it is the final beat.
   logic [31:0] st_seq_ff, st_seq_in;
   logic [12:0] st_len_ff, st_len_in;
   logic [4:0]  st_slot_ff, st_slot_in;

   logic        o_valid_ff, o_valid_in;
   logic [2:0]  o_act_ff, o_act_in;
   logic [31:0] o_seq_ff, o_seq_in;
   logic [12:0] o_len_ff, o_len_in;
   logic [4:0]  o_slot_ff, o_slot_in;
   logic        o_full_ff, o_full_in;
   logic        o_tmo_ff, o_tmo_in;
   logic        o_last_ff, o_last_in;
   logic        p_we, stamp_we;
   logic [PW-1:0] p_wslot, sidx;
   logic        out_free;
   logic [SW:0] wsum;

   assign sidx      = slot_ff[PW-1:0];
   assign out_free  = !o_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == ST_IDLE);
   assign rsp_valid      = o_valid_ff;
   assign rsp_action     = o_act_ff;
   assign rsp_seq_out    = o_seq_ff;
   assign rsp_length_out = o_len_ff;
   assign rsp_slot_out   = o_slot_ff;
   assign rsp_table_full = o_full_ff;
   assign rsp_timed_out  = o_tmo_ff;
   assign rsp_last       = o_last_ff;

   // Ring addresses of the entry under scan and of the next window write.
   always_comb begin
      wsum = {1'b0, seen_old_ff} + (SW+1)'(idx_ff);
      if (wsum > {1'b0, SeenLast}) wsum = wsum - (SW+1)'(SEEN_WINDOW);
      seen_raddr = wsum[SW-1:0];
      wsum = {1'b0, seen_old_ff} + (SW+1)'(seen_cnt_ff);
      if (wsum > {1'b0, SeenLast}) wsum = wsum - (SW+1)'(SEEN_WINDOW);
      seen_waddr = (seen_cnt_ff == SeenFull) ? seen_old_ff : wsum[SW-1:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (cmd_valid) begin
            unique case (cmd.op)
               OP_RX_DATA: state_in = ST_SEEN_SCAN;
               OP_RX_ACK, OP_TX_DATA, OP_TICK: state_in = ST_SLOT_SCAN;
               default: state_in = ST_EMIT;
            endcase
         end
         ST_SEEN_SCAN: if (out_free) begin
            if (idx_ff >= seen_cnt_ff) state_in = ST_EMIT;
            else state_in = ST_SEEN_WAIT;
         end
         ST_SEEN_WAIT: if (seen_rd_ff == cur_ff.seq) state_in = ST_EMIT;
            else state_in = ST_SEEN_SCAN;
         ST_SLOT_SCAN: if (out_free) begin
            if (slot_ff == SlotEnd) state_in = ST_EMIT;
            else if (cur_ff.op == OP_RX_ACK && p_valid_ff[sidx]
                     && p_seq[sidx] == cur_ff.seq) state_in = ST_EMIT;
            else if (cur_ff.op == OP_TX_DATA && !p_valid_ff[sidx]) state_in = ST_EMIT;
         end
         ST_EMIT: if (out_free) begin
            if (cur_ff.op == OP_RX_DATA && !dup_ff) state_in = ST_DELIVER;
            else state_in = ST_DONE;
         end
         ST_DELIVER: if (out_free) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cur_in = cur_ff; next_seq_in = next_seq_ff; seen_cnt_in = seen_cnt_ff;
      seen_old_in = seen_old_ff; idx_in = idx_ff; slot_in = slot_ff;
      any_in = any_ff; dup_in = dup_ff; p_valid_in = p_valid_ff;
      rd_pend_in = 1'b0; seen_we = 1'b0; p_we = 1'b0; stamp_we = 1'b0;
      p_wslot = sidx;
      st_seq_in = st_seq_ff; st_len_in = st_len_ff; st_slot_in = st_slot_ff;
      o_valid_in = o_valid_ff && !rsp_ready;
      o_act_in = o_act_ff; o_seq_in = o_seq_ff; o_len_in = o_len_ff;
      o_slot_in = o_slot_ff; o_full_in = o_full_ff; o_last_in = o_last_ff;
      o_tmo_in = out_free ? cur_ff.tmo : o_tmo_ff;
      unique case (state_ff)
         ST_IDLE: if (cmd_valid) begin
            cur_in = cmd; idx_in = '0; slot_in = '0; any_in = 1'b0; dup_in = 1'b0;
         end
         ST_SEEN_SCAN: if (out_free) begin
            if (idx_ff < seen_cnt_ff) rd_pend_in = 1'b1;
         end
         ST_SEEN_WAIT: begin
            if (seen_rd_ff == cur_ff.seq) dup_in = 1'b1;
            idx_in = idx_ff + CW'(1);
         end
         ST_SLOT_SCAN: if (out_free) begin
            if (slot_ff != SlotEnd) begin
               slot_in = slot_ff + IW'(1);
               unique case (cur_ff.op)
                  OP_RX_ACK: if (p_valid_ff[sidx] && p_seq[sidx] == cur_ff.seq) begin
                     p_valid_in[sidx] = 1'b0; any_in = 1'b1; slot_in = slot_ff;
                  end
                  OP_TX_DATA: if (!p_valid_ff[sidx]) begin
                     any_in = 1'b1; slot_in = slot_ff;
                  end
                  default: if (p_valid_ff[sidx] &&
                               (cur_ff.now - p_stamp[sidx]) > {16'd0, redeliver_timeout}) begin
                     // A later hit proves the held one is not final, so it goes out now.
                     if (any_ff) begin
                        o_valid_in = 1'b1; o_act_in = ACT_RETX; o_seq_in = st_seq_ff;
                        o_len_in = st_len_ff; o_slot_in = st_slot_ff;
                        o_full_in = 1'b0; o_last_in = 1'b0;
                     end
                     st_seq_in = p_seq[sidx]; st_len_in = p_len[sidx];
                     st_slot_in = 5'(slot_ff);
                     stamp_we = 1'b1; any_in = 1'b1;
                  end
               endcase
            end
         end
         ST_EMIT: if (out_free) begin
            o_valid_in = 1'b1; o_full_in = 1'b0; o_last_in = 1'b1;
            o_len_in = '0; o_slot_in = '0; o_seq_in = '0; o_act_in = ACT_STATUS;
            unique case (cur_ff.op)
               OP_RX_ACK: begin
                  o_seq_in = cur_ff.seq; o_len_in = cur_ff.len;
                  o_slot_in = any_ff ? 5'(slot_ff) : 5'd0;
               end
               OP_RX_DATA: begin
                  // The ack is final only for a duplicate; otherwise delivery follows.
                  o_act_in = ACT_TX_ACK; o_seq_in = cur_ff.seq; o_last_in = dup_ff;
                  if (!dup_ff) begin
                     seen_we = 1'b1;
                     if (seen_cnt_ff == SeenFull) begin
                        seen_old_in = (seen_old_ff == SeenLast) ? '0 : seen_old_ff + SW'(1);
                     end else seen_cnt_in = seen_cnt_ff + CW'(1);
                  end
               end
               OP_TX_ACK: begin
                  o_act_in = ACT_TX_ACK; o_seq_in = next_seq_ff;
                  next_seq_in = next_seq_ff + 32'd1;
               end
               OP_TX_DATA: begin
                  o_seq_in = next_seq_ff;
                  if (any_ff) begin
                     o_act_in = ACT_TX_NEW; o_len_in = cur_ff.len;
                     o_slot_in = 5'(slot_ff); p_we = 1'b1;
                     p_valid_in[sidx] = 1'b1; next_seq_in = next_seq_ff + 32'd1;
                  end else o_full_in = 1'b1;
               end
               OP_TICK: if (any_ff) begin
                  o_act_in = ACT_RETX; o_seq_in = st_seq_ff; o_len_in = st_len_ff;
                  o_slot_in = st_slot_ff;
               end
               default: ;
            endcase
         end
         ST_DELIVER: if (out_free) begin
            o_valid_in = 1'b1; o_act_in = ACT_DELIVER; o_seq_in = cur_ff.seq;
            o_len_in = cur_ff.len; o_slot_in = '0; o_full_in = 1'b0; o_last_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_pend_in) seen_rd_ff <= seen_mem[seen_raddr];
      if (seen_we) seen_mem[seen_waddr] <= cur_ff.seq;
      if (p_we) begin
         p_seq[p_wslot]   <= next_seq_ff;
         p_stamp[p_wslot] <= cur_ff.now;
         p_len[p_wslot]   <= cur_ff.len;
      end
      if (stamp_we) p_stamp[sidx] <= cur_ff.now;
      cur_ff <= cur_in; idx_ff <= idx_in; slot_ff <= slot_in;
      any_ff <= any_in; dup_ff <= dup_in;
      st_seq_ff <= st_seq_in; st_len_ff <= st_len_in; st_slot_ff <= st_slot_in;
      o_act_ff <= o_act_in; o_seq_ff <= o_seq_in; o_len_ff <= o_len_in;
      o_slot_ff <= o_slot_in; o_full_ff <= o_full_in; o_tmo_ff <= o_tmo_in;
      o_last_ff <= o_last_in;
      if (reset) begin
         state_ff <= ST_IDLE; o_valid_ff <= 1'b0; next_seq_ff <= '0;
         seen_cnt_ff <= '0; seen_old_ff <= '0; p_valid_ff <= '0;
      end else begin
         state_ff <= state_in; next_seq_ff <= next_seq_in;
         seen_cnt_ff <= seen_cnt_in; seen_old_ff <= seen_old_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/reliable_datagram_arq_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// Control side of a reliable datagram link. A front end stamps each request
// beat with the connection-timeout flag and saturates its length, then queues
// it (two deep) for the back end, which works one item at a time. A received
// data packet is checked against the duplicate window one entry at a time,
// since the window memory is searched one read per step; acks, data sends and
// ticks scan the slot table one slot a cycle while the response output is free.
// Every response beat carries timed_out; the final beat of an item has last.
module reliable_datagram_arq_tracker #(
   parameter int SEEN_WINDOW   = 1024,
   parameter int PENDING_SLOTS = 32,
   parameter int MAX_PAYLOAD   = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic        req_is_ack,
   input  wire logic [31:0] req_seq_in,
   input  wire logic [12:0] req_payload_length,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_action,
   output logic [31:0]      rsp_seq_out,
   output logic [12:0]      rsp_length_out,
   output logic [4:0]       rsp_slot_out,
   output logic             rsp_table_full,
   output logic             rsp_timed_out,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   import rdat_pkg::*;

   logic [15:0] redeliver_ff, connection_ff;
   cmd_type     cmd;
   logic        cmd_valid, cmd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         redeliver_ff  <= REDELIVER_RESET;
         connection_ff <= CONNECTION_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_REDELIVER) redeliver_ff <= csr_wdata;
         if (csr_index == CSR_CONNECTION) connection_ff <= csr_wdata;
      end
   end

   rdat_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_is_ack,
      .req_seq_in, .req_payload_length, .req_now_ms,
      .conn_timeout(connection_ff), .cmd_valid, .cmd_ready, .cmd
   );

   rdat_back #(.SEEN_WINDOW(SEEN_WINDOW), .PENDING_SLOTS(PENDING_SLOTS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .redeliver_timeout(redeliver_ff), .rsp_valid, .rsp_ready, .rsp_action,
      .rsp_seq_out, .rsp_length_out, .rsp_slot_out, .rsp_table_full,
      .rsp_timed_out, .rsp_last
   );
endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import rdat_pkg::*;

   localparam int WINDOW_DEPTH = 1024;
   localparam int SLOT_COUNT   = 32;
   localparam int PAYLOAD_MAX  = 4096;
   localparam int CYCLE_LIMIT  = 3000000;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] seq;
      logic [12:0] len;
      logic [4:0]  slot;
      logic        full;
      logic        tmo;
      logic        last;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic        req_is_ack = 1'b0;
   logic [31:0] req_seq_in = '0;
   logic [12:0] req_payload_length = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_action;
   logic [31:0] rsp_seq_out;
   logic [12:0] rsp_length_out;
   logic [4:0]  rsp_slot_out;
   logic        rsp_table_full;
   logic        rsp_timed_out;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_REDELIVER;
   logic [15:0] csr_wdata = '0;

   reliable_datagram_arq_tracker i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_is_ack(req_is_ack), .req_seq_in(req_seq_in),
      .req_payload_length(req_payload_length), .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_action(rsp_action),
      .rsp_seq_out(rsp_seq_out), .rsp_length_out(rsp_length_out),
      .rsp_slot_out(rsp_slot_out), .rsp_table_full(rsp_table_full),
      .rsp_timed_out(rsp_timed_out), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow state of the link tracker.
   logic [15:0] redeliver_ms;
   logic [15:0] connection_ms;
   logic [31:0] send_seq;
   logic [31:0] rx_time;
   logic [31:0] seen_store [WINDOW_DEPTH];
   int          seen_used;
   int          seen_head;
   logic [31:0] held_seq   [SLOT_COUNT];
   logic [31:0] held_stamp [SLOT_COUNT];
   logic [12:0] held_len   [SLOT_COUNT];
   logic        held_valid [SLOT_COUNT];

   beat_type expected_beats[$];
   int       fail_count = 0;
   int       send_idle_pct = 0;
   int       recv_stall_pct = 0;
   int       hold_off = 0;
   int       cycle_count = 0;
   logic [31:0] clock_ms = 32'd100;

   function automatic beat_type make_beat(action_type a, logic [31:0] s, logic [12:0] l,
                                          logic [4:0] sl, logic f, logic t);
      beat_type b;
      b.action = a; b.seq = s; b.len = l; b.slot = sl; b.full = f; b.tmo = t;
      b.last = 1'b0;
      return b;
   endfunction

   function automatic bit window_lookup_record(logic [31:0] s);
      for (int i = 0; i < seen_used; i++)
         if (seen_store[(seen_head + i) % WINDOW_DEPTH] == s) return 1'b1;
      if (seen_used >= WINDOW_DEPTH) begin
         seen_store[seen_head] = s;
         seen_head = (seen_head + 1) % WINDOW_DEPTH;
      end else begin
         seen_store[(seen_head + seen_used) % WINDOW_DEPTH] = s;
         seen_used++;
      end
      return 1'b0;
   endfunction

   task automatic predict_link(logic [1:0] f, logic ack, logic [31:0] s, logic [12:0] l0,
                               logic [31:0] now);
      beat_type out[$];
      logic [12:0] l;
      logic t;
      logic [4:0] freed;
      bit placed;
      l = (l0 > PAYLOAD_MAX) ? 13'(PAYLOAD_MAX) : l0;
      if (f == FUNC_RECEIVE) rx_time = now;
      t = ((now - rx_time) > {16'd0, connection_ms});
      case (f)
         FUNC_RECEIVE: begin
            if (ack) begin
               freed = '0;
               for (int i = 0; i < SLOT_COUNT; i++)
                  if (held_valid[i] && held_seq[i] == s) begin
                     held_valid[i] = 1'b0; freed = 5'(i); break;
                  end
               out = {out, make_beat(ACT_STATUS, s, l, freed, 1'b0, t)};
            end else begin
               out = {out, make_beat(ACT_TX_ACK, s, '0, '0, 1'b0, t)};
               if (!window_lookup_record(s))
                  out = {out, make_beat(ACT_DELIVER, s, l, '0, 1'b0, t)};
            end
         end
         FUNC_SEND: begin
            if (ack) begin
               out = {out, make_beat(ACT_TX_ACK, send_seq, '0, '0, 1'b0, t)};
               send_seq++;
            end else begin
               placed = 0;
               for (int i = 0; i < SLOT_COUNT; i++)
                  if (!held_valid[i]) begin
                     held_valid[i] = 1'b1; held_seq[i] = send_seq;
                     held_stamp[i] = now; held_len[i] = l;
                     out = {out, make_beat(ACT_TX_NEW, send_seq, l, 5'(i), 1'b0, t)};
                     send_seq++; placed = 1; break;
                  end
               if (!placed) out = {out, make_beat(ACT_STATUS, send_seq, '0, '0, 1'b1, t)};
            end
         end
         FUNC_TICK: begin
            for (int i = 0; i < SLOT_COUNT; i++)
               if (held_valid[i] && (now - held_stamp[i]) > {16'd0, redeliver_ms}) begin
                  out = {out, make_beat(ACT_RETX, held_seq[i], held_len[i], 5'(i), 1'b0, t)};
                  held_stamp[i] = now;
               end
            if (out.size() == 0) out = {out, make_beat(ACT_STATUS, '0, '0, '0, 1'b0, t)};
         end
         default: out = {out, make_beat(ACT_STATUS, '0, '0, '0, 1'b0, t)};
      endcase
      out[out.size() - 1].last = 1'b1;
      foreach (out[i]) expected_beats = {expected_beats, out[i]};
   endtask

   // The request stays valid after acceptance until the next idle cycle or drain,
   // so valid never gets two updates in one time step.
   task automatic send_item(logic [1:0] f, logic ack, logic [31:0] s, logic [12:0] l,
                            logic [31:0] now);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1; req_func <= f; req_is_ack <= ack; req_seq_in <= s;
      req_payload_length <= l; req_now_ms <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_link(f, ack, s, l, now);
   endtask

   task automatic write_csr(logic idx, logic [15:0] v);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_REDELIVER) redeliver_ms = v; else connection_ms = v;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (2 * WINDOW_DEPTH + 40) @(posedge clock);
   endtask

   // Receiver side: stall pattern plus an optional long hold-off.
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      beat_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_action, rsp_seq_out, rsp_length_out, rsp_slot_out,
                rsp_table_full, rsp_timed_out, rsp_last};
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, got);
            fail_count++;
         end else begin
            want = expected_beats.pop_front();
            if (got.action != want.action || got.seq != want.seq || got.len != want.len ||
                got.slot != want.slot || got.full != want.full || got.tmo != want.tmo ||
                got.last != want.last) begin
               $display("%0t: mismatch expected %h actual %h", $time, want, got);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic test_directed();
      logic [31:0] first_seq;
      send_item(FUNC_TICK, 0, 0, 0, 32'd0);
      send_item(FUNC_OTHER, 1, 32'hFFFF_FFFF, 13'h1FFF, 32'hFFFF_FFFF);
      send_item(FUNC_RECEIVE, 0, 32'hFFFF_FFFF, 13'h1FFF, 32'd10);
      send_item(FUNC_RECEIVE, 0, 32'hFFFF_FFFF, 13'd4096, 32'd20);
      send_item(FUNC_RECEIVE, 0, 32'd0, 13'd0, 32'd30);
      send_item(FUNC_SEND, 1, 0, 13'd7, 32'd40);
      first_seq = send_seq;
      send_item(FUNC_SEND, 0, 0, 13'd4097, 32'd50);
      send_item(FUNC_SEND, 0, 0, 13'd0, 32'd60);
      send_item(FUNC_RECEIVE, 1, first_seq, 13'd5, 32'd70);
      send_item(FUNC_RECEIVE, 1, 32'h1234_5678, 13'd5, 32'd80);
      send_item(FUNC_TICK, 0, 0, 0, 32'd90);
      send_item(FUNC_TICK, 0, 0, 0, 32'd5000);
      send_item(FUNC_TICK, 0, 0, 0, 32'd30000);
      send_item(FUNC_TICK, 0, 0, 0, 32'hFFFF_FFF0);
      send_item(FUNC_SEND, 1, 32'hAAAA_AAAA, 13'h0AAA, 32'h5555_5555);
      send_item(FUNC_OTHER, 0, 32'h5555_5555, 13'h1555, 32'hAAAA_AAAA);
   endtask

   // Fill the slot table past full, retransmit via a tick, then send acks to free slots.
   task automatic test_table_full();
      for (int i = 0; i < SLOT_COUNT + 3; i++)
         send_item(FUNC_SEND, 0, $urandom, 13'($urandom_range(4200)), clock_ms + i);
      clock_ms += 100;
      send_item(FUNC_TICK, 0, 0, 0, clock_ms + 32'd65536);
      for (int i = 0; i < 8; i++)
         send_item(FUNC_RECEIVE, 1, send_seq - 32'($urandom_range(40)), 13'd1, clock_ms);
   endtask

   task automatic test_random(int count);
      logic [31:0] s;
      int pick;
      for (int i = 0; i < count; i++) begin
         clock_ms += $urandom_range(3) == 0 ? $urandom_range(70000) : $urandom_range(400);
         pick = $urandom_range(99);
         if (pick < 30)
            send_item(FUNC_SEND, $urandom_range(4) == 0, $urandom, 13'($urandom_range(4200)),
                      clock_ms);
         else if (pick < 50)
            send_item(FUNC_RECEIVE, 1, $urandom_range(1) ? send_seq - 32'($urandom_range(40))
                      : $urandom, 13'($urandom), clock_ms);
         else if (pick < 75) begin
            s = $urandom_range(1) ? 32'($urandom_range(20)) : $urandom;
            send_item(FUNC_RECEIVE, 0, s, 13'($urandom), clock_ms);
         end else if (pick < 95)
            send_item(FUNC_TICK, $urandom_range(1), $urandom, 13'($urandom), clock_ms);
         else
            send_item(FUNC_OTHER, $urandom_range(1), $urandom, 13'($urandom), $urandom);
      end
   endtask

   task automatic test_backpressure();
      hold_off = 400;
      for (int i = 0; i < 12; i++) send_item(FUNC_SEND, 1, 0, 13'd3, clock_ms);
   endtask

   initial begin
      redeliver_ms = REDELIVER_RESET;
      connection_ms = CONNECTION_RESET;
      send_seq = '0; rx_time = '0; seen_used = 0; seen_head = 0;
      for (int i = 0; i < SLOT_COUNT; i++) held_valid[i] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      wait_drained();
      write_csr(CSR_REDELIVER, 16'd1);
      write_csr(CSR_CONNECTION, 16'd1);
      send_idle_pct = 67;
      test_table_full();
      test_random(30);
      wait_drained();
      write_csr(CSR_REDELIVER, 16'hFFFF);
      write_csr(CSR_CONNECTION, 16'hFFFF);
      send_idle_pct = 0; recv_stall_pct = 67;
      test_random(25);
      test_backpressure();
      wait_drained();
      write_csr(CSR_REDELIVER, 16'd300);
      write_csr(CSR_CONNECTION, 16'd2000);
      send_idle_pct = 12; recv_stall_pct = 12;
      test_random(33);
      wait_drained();

      if (fail_count == 0 && expected_beats.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end
endmodule

FILE: filelist.f
hdl/rdat_pkg.sv
hdl/rdat_front.sv
hdl/rdat_back.sv
hdl/reliable_datagram_arq_tracker.sv
test/tb_top.sv
